// File: rtl/dce_pkg.sv
`default_nettype none

package dce_pkg;

   // sequence numbers, byte counters and windows
   localparam int unsigned SEQ_W = 32;

   // configuration register index
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN          = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ALPHA = 2'd1;

   // request kinds
   localparam logic ACTION_ACK    = 1'b0;
   localparam logic ACTION_REDUCE = 1'b1;

endpackage : dce_pkg

`default_nettype wire

// File: rtl/dctcp_congestion_estimator_top.sv
// an ack that leaves the window open goes from S_EXEC straight to S_DONE; an ack that closes it runs
//    S_DIV, S_MUL and S_FIN in that order first, and a reduce request runs S_MUL only before S_DONE
// one request at a time: the next one is taken as soon as the current result sits in the output register
// synchronous reset: alpha = 1.0, gain = 0.0625, counters and window_end cleared, no clearing pass
`default_nettype none

module dctcp_congestion_estimator_top #(
   parameter int unsigned ALPHA_FRAC_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // configuration writes
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [dce_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [ALPHA_FRAC_BITS:0]             csr_wdata,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_action,
   input  wire  [dce_pkg::SEQ_W-1:0]            req_ack_seq,
   input  wire  [dce_pkg::SEQ_W-1:0]            req_snd_una,
   input  wire  [dce_pkg::SEQ_W-1:0]            req_snd_nxt,
   input  wire                                  req_ece_flag,
   input  wire  [dce_pkg::SEQ_W-1:0]            req_cwnd_in,
   // result channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [ALPHA_FRAC_BITS:0]             rsp_alpha_now,
   output logic                                 rsp_window_closed,
   output logic [dce_pkg::SEQ_W-1:0]            rsp_cwnd_out,
   output logic [dce_pkg::SEQ_W-1:0]            rsp_acked_total
);

   import dce_pkg::*;

   // fraction format: AW bits hold 0 .. ONE inclusive
   localparam int unsigned AW    = ALPHA_FRAC_BITS + 1;
   localparam int unsigned CNT_W = $clog2(AW);
   localparam int unsigned ACC_W = SEQ_W + AW;   // cwnd times alpha
   localparam int unsigned PM_W  = 2 * AW;       // gain times fraction
   localparam logic [AW-1:0] ONE       = AW'(1) << ALPHA_FRAC_BITS;
   localparam logic [AW-1:0] GAIN_RST  = ONE >> 4;   // 0.0625
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(AW - 1);

   typedef enum logic [2:0] {
      S_IDLE,     // waiting for a request
      S_EXEC,     // counter update, window check, serial units loaded
      S_DIV,      // marked/acked, one quotient bit a cycle
      S_MUL,      // shift-add multiply, one multiplier bit a cycle
      S_FIN,      // alpha ewma update
      S_DONE      // result into the output register
   } state_type;

   state_type state_ff;

   // configuration and estimator state
   logic [AW-1:0]    gain_ff;
   logic [AW-1:0]    alpha_ff;
   logic [SEQ_W-1:0] acked_cnt_ff;
   logic [SEQ_W-1:0] marked_cnt_ff;
   logic [SEQ_W-1:0] window_end_ff;

   // held request
   logic             act_ff;
   logic [SEQ_W-1:0] ack_seq_ff;
   logic [SEQ_W-1:0] snd_una_ff;
   logic [SEQ_W-1:0] snd_nxt_ff;
   logic             ece_ff;
   logic [SEQ_W-1:0] cwnd_ff;
   logic             closed_ff;

   // serial divider: remainder and divisor, quotient bits shifted in at the lsb, msb first
   logic [SEQ_W:0]   rem_ff;
   logic [SEQ_W-1:0] div_ff;
   logic [AW-1:0]    quo_ff;
   logic             div_zero_ff;

   // serial multiplier: multiplier bits shifted out msb first, two accumulators share them
   logic [AW-1:0]    mplr_ff;
   logic [SEQ_W-1:0] mcand_a_ff;
   logic [AW-1:0]    mcand_m_ff;
   logic [ACC_W-1:0] acc_a_ff;
   logic [PM_W-1:0]  acc_m_ff;
   logic [CNT_W-1:0] step_ff;

   // output register
   logic             rsp_valid_ff;
   logic [AW-1:0]    rsp_alpha_ff;
   logic             rsp_closed_ff;
   logic [SEQ_W-1:0] rsp_cwnd_ff;
   logic [SEQ_W-1:0] rsp_acked_ff;

   // combinational helpers
   logic [SEQ_W-1:0] bytes;
   logic [SEQ_W-1:0] seq_gap;
   logic             window_pass;
   logic [SEQ_W:0]   acked_sum;
   logic [SEQ_W:0]   marked_sum;
   logic [SEQ_W-1:0] acked_sat;
   logic [SEQ_W-1:0] marked_sat;
   logic [SEQ_W+1:0] div_diff;
   logic             quo_bit;
   logic [SEQ_W:0]   rem_kept;
   logic [SEQ_W:0]   rem_in;
   logic [AW-1:0]    quo_in;
   logic [ACC_W-1:0] acc_a_in;
   logic [PM_W-1:0]  acc_m_in;
   logic [AW-1:0]    gain_eff;
   logic [AW:0]      alpha_sum;
   logic [AW-1:0]    alpha_in;
   logic [AW-1:0]    csr_alpha;
   logic [SEQ_W-1:0] cwnd_out_in;
   logic             rsp_load;

   always_comb begin
      // newly acknowledged bytes and serial distance past the window end
      bytes       = ack_seq_ff - snd_una_ff;
      seq_gap     = ack_seq_ff - window_end_ff;
      window_pass = (seq_gap != '0) && !seq_gap[SEQ_W-1];

      // saturating counters
      acked_sum  = {1'b0, acked_cnt_ff} + {1'b0, bytes};
      marked_sum = {1'b0, marked_cnt_ff} + {1'b0, (ece_ff ? bytes : '0)};
      acked_sat  = acked_sum[SEQ_W] ? '1 : acked_sum[SEQ_W-1:0];
      marked_sat = marked_sum[SEQ_W] ? '1 : marked_sum[SEQ_W-1:0];

      // restoring divide step
      div_diff = {1'b0, rem_ff} - {2'b00, div_ff};
      quo_bit  = !div_diff[SEQ_W+1];
      rem_kept = quo_bit ? div_diff[SEQ_W:0] : rem_ff;
      rem_in   = {rem_kept[SEQ_W-1:0], 1'b0};
      quo_in   = {quo_ff[AW-2:0], quo_bit};

      // shift-add multiply step
      acc_a_in = {acc_a_ff[ACC_W-2:0], 1'b0}
               + (mplr_ff[AW-1] ? {{AW{1'b0}}, mcand_a_ff} : '0);
      acc_m_in = {acc_m_ff[PM_W-2:0], 1'b0}
               + (mplr_ff[AW-1] ? {{AW{1'b0}}, mcand_m_ff} : '0);

      // alpha - g*alpha + g*M, never below zero since g is at most one
      gain_eff  = (gain_ff > ONE) ? ONE : gain_ff;
      alpha_sum = {1'b0, alpha_ff} - {1'b0, acc_a_ff[ALPHA_FRAC_BITS +: AW]}
                + {1'b0, acc_m_ff[ALPHA_FRAC_BITS +: AW]};
      alpha_in  = (alpha_sum > {1'b0, ONE}) ? ONE : alpha_sum[AW-1:0];

      csr_alpha = (csr_wdata > ONE) ? ONE : csr_wdata;

      // cwnd * (1 - alpha/2)
      cwnd_out_in = (act_ff == ACTION_REDUCE)
                  ? cwnd_ff - acc_a_ff[ALPHA_FRAC_BITS+1 +: SEQ_W] : '0;

      // result moves into the output register once it is free
      rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         gain_ff       <= GAIN_RST;
         alpha_ff      <= ONE;
         acked_cnt_ff  <= '0;
         marked_cnt_ff <= '0;
         window_end_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // output register: filled from S_DONE, emptied on acceptance
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  act_ff     <= req_action;
                  ack_seq_ff <= req_ack_seq;
                  snd_una_ff <= req_snd_una;
                  snd_nxt_ff <= req_snd_nxt;
                  ece_ff     <= req_ece_flag;
                  cwnd_ff    <= req_cwnd_in;
                  state_ff   <= S_EXEC;
               end
            end

            S_EXEC: begin
               step_ff  <= '0;
               acc_a_ff <= '0;
               acc_m_ff <= '0;
               quo_ff   <= '0;
               if (act_ff == ACTION_REDUCE) begin
                  closed_ff  <= 1'b0;
                  mplr_ff    <= alpha_ff;
                  mcand_a_ff <= cwnd_ff;
                  mcand_m_ff <= '0;
                  state_ff   <= S_MUL;
               end else if (window_pass) begin
                  // window closes: divide the updated counts, then clear them
                  closed_ff     <= 1'b1;
                  window_end_ff <= snd_nxt_ff;
                  acked_cnt_ff  <= '0;
                  marked_cnt_ff <= '0;
                  rem_ff        <= {1'b0, marked_sat};
                  div_ff        <= acked_sat;
                  div_zero_ff   <= (acked_sat == '0);
                  state_ff      <= S_DIV;
               end else begin
                  closed_ff     <= 1'b0;
                  acked_cnt_ff  <= acked_sat;
                  marked_cnt_ff <= marked_sat;
                  state_ff      <= S_DONE;
               end
            end

            S_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               if (step_ff == LAST_STEP) begin
                  // marked never exceeds acked, so the quotient is at most one
                  step_ff    <= '0;
                  mplr_ff    <= gain_eff;
                  mcand_a_ff <= {{(SEQ_W-AW){1'b0}}, alpha_ff};
                  mcand_m_ff <= div_zero_ff ? '0 : quo_in;
                  state_ff   <= S_MUL;
               end else begin
                  step_ff <= step_ff + CNT_W'(1);
               end
            end

            S_MUL: begin
               acc_a_ff <= acc_a_in;
               acc_m_ff <= acc_m_in;
               mplr_ff  <= {mplr_ff[AW-2:0], 1'b0};
               step_ff  <= step_ff + CNT_W'(1);
               if (step_ff == LAST_STEP) begin
                  state_ff <= (act_ff == ACTION_REDUCE) ? S_DONE : S_FIN;
               end
            end

            S_FIN: begin
               alpha_ff <= alpha_in;
               state_ff <= S_DONE;
            end

            S_DONE: begin
               // wait for the output register to free up
               if (rsp_load) begin
                  rsp_alpha_ff  <= alpha_ff;
                  rsp_closed_ff <= closed_ff;
                  rsp_cwnd_ff   <= cwnd_out_in;
                  rsp_acked_ff  <= acked_cnt_ff;
                  state_ff      <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // configuration: the user must write it only while no request is in flight; the block does not enforce this
         if (csr_valid) begin
            unique case (csr_index)
               CSR_GAIN: begin
                  gain_ff <= csr_wdata;
               end
               CSR_INITIAL_ALPHA: begin
                  alpha_ff <= csr_alpha;
               end
               default: begin
                  // unknown index, write dropped
               end
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alpha_now     = rsp_alpha_ff;
   assign rsp_window_closed = rsp_closed_ff;
   assign rsp_cwnd_out      = rsp_cwnd_ff;
   assign rsp_acked_total   = rsp_acked_ff;

   // alpha stays within the fraction range whatever is written
   a_alpha_range : assert property (@(posedge clock) disable iff (reset)
      alpha_ff <= ONE)
      else $error("alpha above one");

   // one request in flight: req_ready is low in the cycle after a request is accepted
   a_single_flight : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   // closing a window clears the byte counter reported with it
   a_close_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_window_closed) |-> (rsp_acked_total == '0))
      else $error("window closed with nonzero count");

   // a reduce request never closes a window
   a_reduce_open : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cwnd_out != '0) |-> !rsp_window_closed)
      else $error("reduce result marks a window close");

endmodule : dctcp_congestion_estimator_top

`default_nettype wire

// File: test/dctcp_congestion_estimator_top_test.sv
typedef struct packed {
   logic        action;
   logic [31:0] ack_seq;
   logic [31:0] snd_una;
   logic [31:0] snd_nxt;
   logic        ece_flag;
   logic [31:0] cwnd_in;
} dce_request_type;

typedef struct packed {
   logic [16:0] alpha_now;
   logic        window_closed;
   logic [31:0] cwnd_out;
   logic [31:0] acked_total;
} dce_result_type;

// alpha estimator shadow and the queue of results still owed by the block
class dce_alpha_board;
   localparam int unsigned FRAC = 16;
   localparam bit [63:0] ONE = 64'd1 << FRAC;

   bit [16:0]      gain;
   bit [16:0]      alpha;
   bit [31:0]      acked;
   bit [31:0]      marked;
   bit [31:0]      win_end;
   dce_result_type owed[$];
   int unsigned    errors;
   int unsigned    checked;
   int unsigned    n_acks;
   int unsigned    n_reduces;
   int unsigned    closes;
   int unsigned    csr_writes;

   function new();
      gain       = 17'd4096;
      alpha      = 17'd65536;
      acked      = '0;
      marked     = '0;
      win_end    = '0;
      errors     = 0;
      checked    = 0;
      n_acks     = 0;
      n_reduces  = 0;
      closes     = 0;
      csr_writes = 0;
   endfunction

   static function bit [63:0] cap_one(bit [63:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

   static function bit [31:0] sat_add(bit [31:0] x, bit [31:0] y);
      bit [32:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch after %0d results: %s got 0x%0h, want 0x%0h",
               checked, what, got, want);
   endtask

   function void apply_csr(logic [1:0] index, logic [16:0] data);
      csr_writes++;
      if (index == dce_pkg::CSR_GAIN) begin
         gain = data;
      end else if (index == dce_pkg::CSR_INITIAL_ALPHA) begin
         alpha = 17'(cap_one({47'd0, data}));
      end
   endfunction

   function void note_request(dce_request_type r);
      bit [31:0]      bytes;
      bit [31:0]      seq_gap;
      bit [63:0]      g;
      bit [63:0]      a;
      bit [63:0]      m;
      dce_result_type e;
      e = '0;
      if (r.action == dce_pkg::ACTION_ACK) begin
         n_acks++;
         bytes   = r.ack_seq - r.snd_una;
         seq_gap = r.ack_seq - win_end;
         acked   = sat_add(acked, bytes);
         if (r.ece_flag)
            marked = sat_add(marked, bytes);
         // serial compare: strictly ahead, less than half the space
         if (seq_gap != 0 && !seq_gap[31]) begin
            g = cap_one({47'd0, gain});
            a = cap_one({47'd0, alpha});
            m = '0;
            if (acked != 0)
               m = cap_one(({32'd0, marked} << FRAC) / {32'd0, acked});
            alpha   = 17'(cap_one(a - ((g * a) >> FRAC) + ((g * m) >> FRAC)));
            win_end = r.snd_nxt;
            acked   = '0;
            marked  = '0;
            e.window_closed = 1'b1;
            closes++;
         end
      end else begin
         n_reduces++;
         a = cap_one({47'd0, alpha});
         g = ({32'd0, r.cwnd_in} * a) >> (FRAC + 1);
         e.cwnd_out = r.cwnd_in - g[31:0];
      end
      e.alpha_now   = alpha;
      e.acked_total = acked;
      owed.push_back(e);
   endfunction

   task check_result(dce_result_type got);
      dce_result_type want;
      if (owed.size() == 0) begin
         report("result with no request outstanding", 64'(got.cwnd_out), '0);
         return;
      end
      want = owed.pop_front();
      checked++;
      if (got.alpha_now !== want.alpha_now)
         report("alpha_now", 64'(got.alpha_now), 64'(want.alpha_now));
      if (got.window_closed !== want.window_closed)
         report("window_closed", 64'(got.window_closed), 64'(want.window_closed));
      if (got.cwnd_out !== want.cwnd_out)
         report("cwnd_out", 64'(got.cwnd_out), 64'(want.cwnd_out));
      if (got.acked_total !== want.acked_total)
         report("acked_total", 64'(got.acked_total), 64'(want.acked_total));
   endtask
endclass

module dctcp_congestion_estimator_top_test;

   localparam int unsigned FRAC             = 16;
   localparam int unsigned PHASES           = 8;
   localparam int unsigned RANDOM_PER_PHASE = 186;

   // indexes past the two real registers, writes there must be dropped
   localparam logic [dce_pkg::CSR_IDX_W-1:0] CSR_BAD_LO = 2'd2;
   localparam logic [dce_pkg::CSR_IDX_W-1:0] CSR_BAD_HI = 2'd3;

   typedef enum int unsigned {STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_LONG} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [dce_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [FRAC:0]                 csr_wdata = '0;

   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic        req_action   = 1'b0;
   logic [31:0] req_ack_seq  = '0;
   logic [31:0] req_snd_una  = '0;
   logic [31:0] req_snd_nxt  = '0;
   logic        req_ece_flag = 1'b0;
   logic [31:0] req_cwnd_in  = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [FRAC:0] rsp_alpha_now;
   logic        rsp_window_closed;
   logic [31:0] rsp_cwnd_out;
   logic [31:0] rsp_acked_total;

   dce_alpha_board board = new();

   // sender burst bookkeeping and the tcp flow that well-formed acks follow
   int unsigned burst_left = 0;
   logic [31:0] flow_una = '0;
   logic [31:0] flow_nxt = '0;
   int unsigned mark_pct = 0;

   // receiver stall pattern state
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned mode_left  = 0;
   int unsigned stall_left = 0;

   always #1 clock = ~clock;

   dctcp_congestion_estimator_top #(
      .ALPHA_FRAC_BITS(FRAC)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_ack_seq      (req_ack_seq),
      .req_snd_una      (req_snd_una),
      .req_snd_nxt      (req_snd_nxt),
      .req_ece_flag     (req_ece_flag),
      .req_cwnd_in      (req_cwnd_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_alpha_now    (rsp_alpha_now),
      .rsp_window_closed(rsp_window_closed),
      .rsp_cwnd_out     (rsp_cwnd_out),
      .rsp_acked_total  (rsp_acked_total)
   );

   // all handshakes are observed at the rising edge, where inputs have been
   // stable since the falling edge, so nothing here races the block
   always @(posedge clock) begin : watch
      dce_request_type seen_req;
      dce_result_type  seen_rsp;
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.apply_csr(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            seen_req = {req_action, req_ack_seq, req_snd_una, req_snd_nxt,
                        req_ece_flag, req_cwnd_in};
            board.note_request(seen_req);
         end
         if (rsp_valid && rsp_ready) begin
            seen_rsp = {rsp_alpha_now, rsp_window_closed, rsp_cwnd_out, rsp_acked_total};
            board.check_result(seen_rsp);
         end
      end
   end

   // receiver: switches between always ready, random stalls, a sparse
   // pattern and long stall bursts, each for a random stretch of cycles
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_ready = 1'b1;
         end
         STALL_RANDOM: begin
            rsp_ready = ($urandom_range(0, 3) != 0);
         end
         STALL_SPARSE: begin
            rsp_ready = (mode_left % 4 == 0);
         end
         default: begin
            if (stall_left == 0) begin
               rsp_ready  = ~rsp_ready;
               stall_left = $urandom_range(1, 40);
            end else begin
               stall_left--;
            end
         end
      endcase
   end

   function automatic dce_request_type make_req(logic action, logic [31:0] ack, logic [31:0] una,
                                                logic [31:0] nxt, logic ece, logic [31:0] cwnd);
      return {action, ack, una, nxt, ece, cwnd};
   endfunction

   // mostly acks that follow one flow in order, with reduce requests and
   // stray or broken acks mixed in
   function automatic dce_request_type next_random_request();
      dce_request_type r;
      int unsigned     pick;
      pick = $urandom_range(0, 99);
      r.ack_seq  = $urandom;
      r.snd_una  = $urandom;
      r.snd_nxt  = $urandom;
      r.ece_flag = 1'($urandom_range(0, 1));
      r.cwnd_in  = $urandom;
      if (pick < 10) begin
         r.action = dce_pkg::ACTION_REDUCE;
         case ($urandom_range(0, 3))
            0: begin
               r.cwnd_in = $urandom;
            end
            1: begin
               r.cwnd_in = 32'hFFFF_FFFF;
            end
            default: begin
               r.cwnd_in = $urandom_range(0, 1 << 20);
            end
         endcase
      end else if (pick < 25) begin
         // stray ack: arbitrary ack and una, so byte counts are huge or
         // wrap, but keep snd_nxt near the flow so it can resume
         r.action  = dce_pkg::ACTION_ACK;
         r.snd_nxt = flow_nxt + $urandom_range(0, 4000);
      end else begin
         if (flow_nxt - flow_una < 32'd65536)
            flow_nxt += $urandom_range(0, 3000);
         r.action   = dce_pkg::ACTION_ACK;
         r.snd_una  = flow_una;
         r.snd_nxt  = flow_nxt;
         r.ack_seq  = flow_una + $urandom_range(0, flow_nxt - flow_una);
         r.ece_flag = ($urandom_range(0, 99) < mark_pct);
         flow_una   = r.ack_seq;
      end
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance;
   // valid stays high between requests of one burst
   task automatic send_request(input dce_request_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         req_valid = 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      {req_action, req_ack_seq, req_snd_una, req_snd_nxt, req_ece_flag, req_cwnd_in} = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid = 1'b0;
      while (board.owed.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [dce_pkg::CSR_IDX_W-1:0] index, input logic [FRAC:0] data);
      csr_index = index;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      logic [FRAC:0] gain_w;
      logic [FRAC:0] alpha_w;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed requests at the reset settings (alpha 1.0, gain 0.0625)
      send_request(make_req(dce_pkg::ACTION_REDUCE, '0, '0, '0, 1'b0, 32'hFFFF_FFFF));
      send_request(make_req(dce_pkg::ACTION_REDUCE, '1, '1, '1, 1'b1, '0));
      // wrapped byte count saturates both counters, ack sits on window_end
      send_request(make_req(dce_pkg::ACTION_ACK, '0, 32'd1, '0, 1'b1, '0));
      send_request(make_req(dce_pkg::ACTION_ACK, '0, 32'h10, '0, 1'b1, '1));
      // exactly half the sequence space ahead does not close the window
      send_request(make_req(dce_pkg::ACTION_ACK, 32'h8000_0000, 32'h8000_0000, '0, 1'b0, '0));
      // closes with both counters saturated, so the marked fraction is one
      send_request(make_req(dce_pkg::ACTION_ACK, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_1000, 1'b0, '0));
      send_request(make_req(dce_pkg::ACTION_REDUCE, '0, '0, '0, 1'b0, 32'h1234_5678));
      // closes with nothing acked: marked fraction taken as zero
      send_request(make_req(dce_pkg::ACTION_ACK, 32'h8000_1001, 32'h8000_1001,
                            32'h8000_2000, 1'b0, '0));
      send_request(make_req(dce_pkg::ACTION_ACK, 32'h8000_2000, 32'h8000_1001,
                            32'h8000_3000, 1'b1, '0));
      send_request(make_req(dce_pkg::ACTION_ACK, 32'h8000_2800, 32'h8000_2000,
                            32'h8000_3000, 1'b0, '0));
      send_request(make_req(dce_pkg::ACTION_ACK, '1, '0, '1, 1'b1, '1));
      send_request(make_req(dce_pkg::ACTION_REDUCE, '1, '1, '1, 1'b1, '1));
      send_request(make_req(dce_pkg::ACTION_ACK, '0, '0, '0, 1'b0, '0));

      for (int p = 0; p < PHASES; p++) begin
         // registers only change with nothing in flight
         wait_until_drained();
         if (p != 0) begin
            case (p)
               1: begin
                  gain_w  = '0;
                  alpha_w = '0;
               end
               2: begin
                  gain_w  = 17'd65536;
                  alpha_w = 17'd65536;
               end
               3: begin
                  gain_w  = '1;
                  alpha_w = '1;
               end
               4: begin
                  gain_w  = 17'd1;
                  alpha_w = 17'd1;
               end
               6: begin
                  gain_w  = 17'd32768;
                  alpha_w = '0;
               end
               default: begin
                  gain_w  = 17'($urandom_range(0, 17'h1FFFF));
                  alpha_w = 17'($urandom_range(0, 17'h1FFFF));
               end
            endcase
            write_csr(dce_pkg::CSR_GAIN, gain_w);
            write_csr(dce_pkg::CSR_INITIAL_ALPHA, alpha_w);
            if (p == 2 || p == 5) begin
               write_csr(CSR_BAD_LO, '1);
               write_csr(CSR_BAD_HI, 17'($urandom_range(0, 17'h1FFFF)));
            end
         end

         case (p)
            1: begin
               mark_pct = 0;
            end
            2: begin
               mark_pct = 100;
            end
            default: begin
               mark_pct = $urandom_range(0, 100);
            end
         endcase

         // move the flow somewhere new and close the window once so that
         // window_end follows it
         flow_una = $urandom;
         flow_nxt = flow_una + $urandom_range(0, 8000);
         send_request(make_req(dce_pkg::ACTION_ACK, board.win_end + 32'd1,
                               board.win_end + 32'd1, flow_nxt, 1'b0, $urandom));

         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            // sender holds off mid phase until every result is back
            if (i == RANDOM_PER_PHASE / 2)
               wait_until_drained();
            send_request(next_random_request());
         end
      end

      wait_until_drained();
      repeat (60) @(negedge clock);

      $display("ran %0d requests: %0d acks, %0d reduce requests, %0d windows closed",
               board.n_acks + board.n_reduces, board.n_acks, board.n_reduces, board.closes);
      $display("%0d register writes across %0d settings, %0d results compared, %0d mismatches",
               board.csr_writes, PHASES, board.checked, board.errors);
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // safety net, several times the slowest legal run
   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", board.owed.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
